// File: rtl/crtl_pkg.sv
package crtl_pkg;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 32;
  localparam int SHAMT_W = 5;
  localparam int LEFT_W = 3;

  // integer length minus one, by low nibble of the first byte
  localparam logic [LEFT_W-1:0] LEN_M1 [16] = '{
    3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd1, 3'd0, 3'd3,
    3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd1, 3'd0, 3'd4
  };

  // right shift of the 32-bit window, by low nibble of the first byte
  localparam logic [SHAMT_W-1:0] SHIFT_AMT [16] = '{
    5'h19, 5'h12, 5'h19, 5'h0b, 5'h19, 5'h12, 5'h19, 5'h04,
    5'h19, 5'h12, 5'h19, 5'h0b, 5'h19, 5'h12, 5'h19, 5'h00
  };

  localparam logic [WORD_W-1:0] NO_STATE = '1;

  typedef struct packed {
    logic               done;
    logic [WORD_W-1:0]  value;
    logic [WORD_W-1:0]  window;
    logic [SHAMT_W-1:0] shamt;
    logic [LEFT_W-1:0]  left;
  } vint_t;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] state;
    logic              trunc;
  } res_t;

endpackage

// File: rtl/crtl_varint.sv
module crtl_varint (
  input  logic [crtl_pkg::BYTE_W-1:0]  byte_in,
  input  logic [crtl_pkg::LEFT_W-1:0]  left,
  input  logic [crtl_pkg::WORD_W-1:0]  window,
  input  logic [crtl_pkg::SHAMT_W-1:0] shamt,
  output crtl_pkg::vint_t              vint
);
  import crtl_pkg::*;

  always_comb begin
    if (left == '0) begin
      vint.window = {byte_in, {(WORD_W-BYTE_W){1'b0}}};
      vint.shamt  = SHIFT_AMT[byte_in[3:0]];
      vint.left   = LEN_M1[byte_in[3:0]];
    end else begin
      vint.window = {byte_in, window[WORD_W-1:BYTE_W]};
      vint.shamt  = shamt;
      vint.left   = left - LEFT_W'(1);
    end
    vint.done  = (vint.left == '0);
    vint.value = vint.window >> vint.shamt;
  end

endmodule

// File: rtl/crtl_walker.sv
module crtl_walker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [crtl_pkg::BYTE_W-1:0] byte_in,
  input  logic                        first,
  input  logic                        last,
  input  logic [crtl_pkg::WORD_W-1:0] offset,
  output crtl_pkg::res_t              res
);
  import crtl_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_COUNT, PH_DELTA, PH_STATE, PH_DONE
  } phase_t;

  phase_t              phase_r, phase_nxt, ph;
  logic [LEFT_W-1:0]   left_r, left_in;
  logic [WORD_W-1:0]   window_r, window_in;
  logic [SHAMT_W-1:0]  shamt_r, shamt_in;
  logic [WORD_W-1:0]   regions_r, regions_in, regions_nxt;
  logic [WORD_W-1:0]   run_r, run_in, run_nxt;
  logic [WORD_W-1:0]   cur_r, cur_in, cur_nxt;
  logic [WORD_W-1:0]   tgt_r, tgt_nxt;
  logic [LEFT_W-1:0]   left_nxt;
  logic [WORD_W-1:0]   window_nxt;
  logic [SHAMT_W-1:0]  shamt_nxt;
  vint_t               vint;

  // restart on first byte
  always_comb begin
    if (first) begin
      ph         = PH_COUNT;
      left_in    = '0;
      window_in  = '0;
      shamt_in   = '0;
      regions_in = '0;
      run_in     = '0;
      cur_in     = NO_STATE;
      tgt_nxt    = offset;
    end else begin
      ph         = phase_r;
      left_in    = left_r;
      window_in  = window_r;
      shamt_in   = shamt_r;
      regions_in = regions_r;
      run_in     = run_r;
      cur_in     = cur_r;
      tgt_nxt    = tgt_r;
    end
  end

  crtl_varint u_varint (
    .byte_in (byte_in),
    .left    (left_in),
    .window  (window_in),
    .shamt   (shamt_in),
    .vint    (vint)
  );

  always_comb begin
    phase_nxt   = ph;
    left_nxt    = left_in;
    window_nxt  = window_in;
    shamt_nxt   = shamt_in;
    regions_nxt = regions_in;
    run_nxt     = run_in;
    cur_nxt     = cur_in;
    res.valid   = 1'b0;
    res.trunc   = 1'b0;
    if (ph == PH_COUNT || ph == PH_DELTA || ph == PH_STATE) begin
      left_nxt   = vint.left;
      window_nxt = vint.window;
      shamt_nxt  = vint.shamt;
      if (vint.done) begin
        unique case (ph)
          PH_COUNT: begin
            regions_nxt = vint.value;
            if (vint.value == '0) res.valid = 1'b1;
            else phase_nxt = PH_DELTA;
          end
          PH_DELTA: begin
            run_nxt = run_in + vint.value;
            if (tgt_nxt < run_nxt) res.valid = 1'b1;
            else phase_nxt = PH_STATE;
          end
          default: begin
            cur_nxt     = vint.value - WORD_W'(1);
            regions_nxt = regions_in - WORD_W'(1);
            if (regions_nxt == '0) res.valid = 1'b1;
            else phase_nxt = PH_DELTA;
          end
        endcase
      end
      if (!res.valid && last) begin
        res.valid = 1'b1;
        res.trunc = 1'b1;
      end
      if (res.valid) phase_nxt = PH_DONE;
    end
    res.state = cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      left_r    <= '0;
      window_r  <= '0;
      shamt_r   <= '0;
      regions_r <= '0;
      run_r     <= '0;
      cur_r     <= NO_STATE;
      tgt_r     <= '0;
    end else if (en) begin
      phase_r   <= phase_nxt;
      left_r    <= left_nxt;
      window_r  <= window_nxt;
      shamt_r   <= shamt_nxt;
      regions_r <= regions_nxt;
      run_r     <= run_nxt;
      cur_r     <= cur_nxt;
      tgt_r     <= tgt_nxt;
    end
  end

endmodule

// File: rtl/compressed_region_table_lookup_unit.sv
// Region table lookup: streams a compressed region table one byte per request
// (tuser marks the first byte and restarts the walk, carrying the searched
// code offset in tdata; tlast marks the last available byte) and returns one
// result per walk: the state of the last region starting at or below the
// offset, or -1, with tuser set when the table ran out first. One byte is
// taken every cycle while the output is not stalled; a byte passes an input
// register, the decode and walk logic, and reaches the result register, so
// a result is offered from the result register once the byte that ends the
// walk has been processed. Bytes outside a walk give no result.
module compressed_region_table_lookup_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // table_byte[7:0], code_offset[39:8]
  input  logic        in_tuser,   // first_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // region_state[31:0]
  output logic        out_tuser   // truncated
);
  import crtl_pkg::*;

  logic                s1_valid_r;
  logic [BYTE_W-1:0]   s1_byte_r;
  logic                s1_first_r;
  logic                s1_last_r;
  logic [WORD_W-1:0]   s1_offset_r;
  logic                out_valid_r;
  logic [WORD_W-1:0]   out_state_r;
  logic                out_trunc_r;
  logic                proc_en;
  res_t                res;

  assign proc_en   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || proc_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_byte_r   <= in_tdata[7:0];
      s1_offset_r <= in_tdata[39:8];
      s1_first_r  <= in_tuser;
      s1_last_r   <= in_tlast;
    end
  end

  crtl_walker u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (proc_en),
    .byte_in (s1_byte_r),
    .first   (s1_first_r),
    .last    (s1_last_r),
    .offset  (s1_offset_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_en && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (proc_en && res.valid) begin
      out_state_r <= res.state;
      out_trunc_r <= res.trunc;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_state_r;
  assign out_tuser  = out_trunc_r;

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    proc_en && res.valid |=> out_tvalid)
    else $error("result lost on its way to the output register");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !proc_en |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_last_r))
    else $error("stalled input stage changed");

  a_trunc_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    proc_en && res.valid && res.trunc |-> s1_last_r)
    else $error("truncated result without a last byte");

endmodule
